[design/dur_pkg.sv]
// ----------------------------------------------------------------------------
// dur_pkg
// Shared constants, types and the tick-to-distance conversion for the dual
// ultrasonic ranger.
// ----------------------------------------------------------------------------
package dur_pkg;

  localparam int NUM_SENSORS     = 2;
  localparam int COUNT_WIDTH     = 16;
  localparam int PHASE_WIDTH     = 16;
  localparam int GAP_WIDTH       = 16;
  localparam int TRIG_WIDTH      = 8;
  localparam int TIMEOUT_WIDTH   = 16;
  localparam int CFG_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int DIST_WIDTH      = 11;
  localparam int DIST_MUL_WIDTH  = 11;
  localparam int DIST_SHIFT      = 16;
  localparam int PROD_WIDTH      = COUNT_WIDTH + DIST_MUL_WIDTH;

  localparam logic [DIST_MUL_WIDTH-1:0] DIST_MUL = 11'd1124;
  localparam logic [PROD_WIDTH-1:0]     DIST_MAX = PROD_WIDTH'(2047);

  localparam logic [GAP_WIDTH-1:0]     GAP_RESET     = 16'd100;
  localparam logic [TRIG_WIDTH-1:0]    TRIG_RESET    = 8'd10;
  localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 16'd20000;

  typedef enum logic [2:0] {
    PH_GAP  = 3'b001,
    PH_TRIG = 3'b010,
    PH_MEAS = 3'b100
  } phase_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_GAP     = 2'd0,
    REG_TRIG    = 2'd1,
    REG_TIMEOUT = 2'd2
  } reg_index_t;

  // per-tick control from the sequencer to every lane
  typedef struct packed {
    logic clear;
    logic meas;
    logic win_end;
  } lane_ctrl_t;

  // next-state view of one lane
  typedef struct packed {
    logic                   resolved;
    logic                   timed_out;
    logic [COUNT_WIDTH-1:0] count;
  } lane_stat_t;

  // result of one tick before distance conversion
  typedef struct packed {
    logic                                   trig;
    logic                                   done;
    logic [NUM_SENSORS-1:0]                 err;
    logic [NUM_SENSORS-1:0][COUNT_WIDTH-1:0] cnt;
  } stage_t;

  function automatic logic [DIST_WIDTH-1:0] to_cm(input logic [COUNT_WIDTH-1:0] ticks);
    logic [PROD_WIDTH-1:0] prod;
    logic [PROD_WIDTH-1:0] q;
    prod = PROD_WIDTH'(ticks) * PROD_WIDTH'(DIST_MUL);
    q    = prod >> DIST_SHIFT;
    if (q > DIST_MAX) begin
      q = DIST_MAX;
    end
    return q[DIST_WIDTH-1:0];
  endfunction

endpackage

[design/dur_if.sv]
// ----------------------------------------------------------------------------
// dur_if
// Valid/ready channels for echo ticks in and ranging results out.
// ----------------------------------------------------------------------------
interface dur_in_if;
  logic valid;
  logic ready;
  logic echo_level_a;
  logic echo_level_b;

  modport source (output valid, output echo_level_a, output echo_level_b, input ready);
  modport sink   (input valid, input echo_level_a, input echo_level_b, output ready);
endinterface

interface dur_out_if;
  logic                           valid;
  logic                           ready;
  logic                           trigger_level;
  logic                           done_res;
  logic [dur_pkg::DIST_WIDTH-1:0] distance_a;
  logic [dur_pkg::DIST_WIDTH-1:0] distance_b;
  logic                           error_a;
  logic                           error_b;

  modport source (output valid, output trigger_level, output done_res, output distance_a,
                  output distance_b, output error_a, output error_b, input ready);
  modport sink   (input valid, input trigger_level, input done_res, input distance_a,
                  input distance_b, input error_a, input error_b, output ready);
endinterface

[design/dual_ultrasonic_ranger_core.sv]
// ----------------------------------------------------------------------------
// dual_ultrasonic_ranger_core
// A tick's result is registered in s1 and then in the result register.
// Throughput: one tick per cycle unless the output stalls; the phase
// sequencer and the lane timers update in the transfer cycle and the
// distance multiply has its own stage. Reset: synchronous; gap phase,
// counters and flags cleared, registers at defaults, no result pending.
// ----------------------------------------------------------------------------
module dual_ultrasonic_ranger_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [dur_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [dur_pkg::CFG_WIDTH-1:0]       cfg_data,
  dur_in_if.sink                              echo,
  dur_out_if.source                           result
);

  logic [dur_pkg::GAP_WIDTH-1:0]     gap_ticks;
  logic [dur_pkg::TRIG_WIDTH-1:0]    trigger_ticks;
  logic [dur_pkg::TIMEOUT_WIDTH-1:0] timeout_ticks;

  dur_pkg::phase_t                 phase;
  dur_pkg::phase_t                 phase_next;
  dur_pkg::phase_t                 phase_eff;
  logic [dur_pkg::PHASE_WIDTH-1:0] phase_count;
  logic [dur_pkg::PHASE_WIDTH-1:0] phase_count_next;
  logic [dur_pkg::PHASE_WIDTH-1:0] count_eff;
  logic [dur_pkg::PHASE_WIDTH-1:0] count_inc;
  logic [dur_pkg::PHASE_WIDTH-1:0] trig_len;
  logic [dur_pkg::PHASE_WIDTH-1:0] win_len;

  logic                                    accept;
  logic                                    take;
  logic                                    s1_valid;
  logic                                    all_resolved;
  dur_pkg::stage_t                         s1;
  dur_pkg::stage_t                         s1_next;
  dur_pkg::lane_ctrl_t                     ctrl;
  dur_pkg::lane_stat_t [dur_pkg::NUM_SENSORS-1:0] stat;
  logic [dur_pkg::NUM_SENSORS-1:0]         level;
  logic [dur_pkg::NUM_SENSORS-1:0]         res_vec;
  logic [1:0]                              pins;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks     <= dur_pkg::GAP_RESET;
      trigger_ticks <= dur_pkg::TRIG_RESET;
      timeout_ticks <= dur_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dur_pkg::REG_GAP:     gap_ticks     <= cfg_data[dur_pkg::GAP_WIDTH-1:0];
        dur_pkg::REG_TRIG:    trigger_ticks <= cfg_data[dur_pkg::TRIG_WIDTH-1:0];
        dur_pkg::REG_TIMEOUT: timeout_ticks <= cfg_data[dur_pkg::TIMEOUT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign echo.ready = !s1_valid || take;
  assign accept     = echo.valid && echo.ready;

  assign trig_len = (trigger_ticks == '0) ? dur_pkg::PHASE_WIDTH'(1)
                                          : dur_pkg::PHASE_WIDTH'(trigger_ticks);
  assign win_len  = (timeout_ticks == '0) ? dur_pkg::PHASE_WIDTH'(1)
                                          : dur_pkg::PHASE_WIDTH'(timeout_ticks);

  // phase sequencer
  always_comb begin
    phase_eff        = phase;
    count_eff        = phase_count;
    if (phase == dur_pkg::PH_GAP && phase_count >= dur_pkg::PHASE_WIDTH'(gap_ticks)) begin
      phase_eff = dur_pkg::PH_TRIG;
      count_eff = '0;
    end
    count_inc        = count_eff + 1'b1;
    phase_next       = phase_eff;
    phase_count_next = count_eff;
    ctrl             = '0;
    s1_next          = '0;
    unique case (phase_eff)
      dur_pkg::PH_GAP: begin
        phase_count_next = count_inc;
      end
      dur_pkg::PH_TRIG: begin
        s1_next.trig = 1'b1;
        if (count_inc >= trig_len) begin
          phase_next       = dur_pkg::PH_MEAS;
          phase_count_next = '0;
          ctrl.clear       = 1'b1;
        end else begin
          phase_count_next = count_inc;
        end
      end
      dur_pkg::PH_MEAS: begin
        if (count_eff != '1) begin
          phase_count_next = count_inc;
        end
        ctrl.meas    = 1'b1;
        ctrl.win_end = phase_count_next >= win_len;
        s1_next.done = all_resolved;
        if (all_resolved) begin
          phase_next       = dur_pkg::PH_GAP;
          phase_count_next = '0;
        end
      end
      default: begin
        phase_next       = dur_pkg::PH_GAP;
        phase_count_next = '0;
      end
    endcase
    for (int i = 0; i < dur_pkg::NUM_SENSORS; i++) begin
      s1_next.err[i] = stat[i].timed_out;
      s1_next.cnt[i] = stat[i].count;
    end
  end

  assign pins = {echo.echo_level_b, echo.echo_level_a};

  for (genvar i = 0; i < dur_pkg::NUM_SENSORS; i++) begin : g_lane
    if (i < 2) begin : g_pin
      assign level[i] = pins[i];
    end else begin : g_nopin
      assign level[i] = 1'b0;
    end
    assign res_vec[i] = stat[i].resolved;

    dur_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .en    (accept),
      .level (level[i]),
      .ctrl  (ctrl),
      .stat  (stat[i])
    );
  end

  assign all_resolved = &res_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= dur_pkg::PH_GAP;
      phase_count <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        phase_count <= phase_count_next;
      end
      if (echo.ready) begin
        s1_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  dur_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .take     (take),
    .result   (result)
  );

`ifndef SYNTHESIS
  a_done_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && s1_next.done |=> phase == dur_pkg::PH_GAP && phase_count == '0)
    else $error("done transfer did not restart the gap");

  a_trig_not_done: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(s1.trig && s1.done))
    else $error("trigger and done in the same tick");
`endif

endmodule

[design/dur_lane.sv]
// ----------------------------------------------------------------------------
// dur_lane
// Echo timer for one sensor: rise detect, saturating duration count and
// timeout flag inside the measuring window.
// ----------------------------------------------------------------------------
module dur_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                level,
  input  dur_pkg::lane_ctrl_t ctrl,
  output dur_pkg::lane_stat_t stat
);

  logic                            prev;
  logic                            seen;
  logic                            resolved;
  logic                            timed_out;
  logic [dur_pkg::COUNT_WIDTH-1:0] count;

  logic                            seen_next;
  logic                            resolved_next;
  logic                            timed_out_next;
  logic [dur_pkg::COUNT_WIDTH-1:0] count_next;

  always_comb begin
    seen_next      = seen;
    resolved_next  = resolved;
    timed_out_next = timed_out;
    count_next     = count;
    if (ctrl.clear) begin
      seen_next      = 1'b0;
      resolved_next  = 1'b0;
      timed_out_next = 1'b0;
      count_next     = '0;
    end else if (ctrl.meas && !resolved) begin
      if (seen) begin
        if (count != '1) begin
          count_next = count + 1'b1;
        end
        if (!level) begin
          resolved_next = 1'b1;
        end
      end else if (level && !prev) begin
        seen_next  = 1'b1;
        count_next = '0;
      end
      // an echo end on the last window tick wins over the timeout
      if (!resolved_next && ctrl.win_end) begin
        resolved_next  = 1'b1;
        timed_out_next = 1'b1;
      end
    end
  end

  assign stat.resolved  = resolved_next;
  assign stat.timed_out = timed_out_next;
  assign stat.count     = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= 1'b0;
      seen      <= 1'b0;
      resolved  <= 1'b0;
      timed_out <= 1'b0;
      count     <= '0;
    end else if (en) begin
      prev      <= level;
      seen      <= seen_next;
      resolved  <= resolved_next;
      timed_out <= timed_out_next;
      count     <= count_next;
    end
  end

endmodule

[design/dur_merge.sv]
// ----------------------------------------------------------------------------
// dur_merge
// Output stage: combines the lanes' counts and flags into the result and
// converts durations to centimeters.
// ----------------------------------------------------------------------------
module dur_merge (
  input  logic              clk,
  input  logic              rst,
  input  logic              s1_valid,
  input  dur_pkg::stage_t   s1,
  output logic              take,
  dur_out_if.source         result
);

  logic [1:0][dur_pkg::DIST_WIDTH-1:0] dist_cm;
  logic [1:0]                          err;

  for (genvar i = 0; i < 2; i++) begin : g_pin
    if (i < dur_pkg::NUM_SENSORS) begin : g_used
      assign err[i]     = s1.done && s1.err[i];
      assign dist_cm[i] = (s1.done && !s1.err[i]) ? dur_pkg::to_cm(s1.cnt[i]) : '0;
    end else begin : g_unused
      assign err[i]     = 1'b0;
      assign dist_cm[i] = '0;
    end
  end

  assign take = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.trigger_level <= s1.trig;
      result.done_res      <= s1.done;
      result.distance_a    <= dist_cm[0];
      result.distance_b    <= dist_cm[1];
      result.error_a       <= err[0];
      result.error_b       <= err[1];
    end
  end

`ifndef SYNTHESIS
  a_err_no_dist: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.error_a |-> result.distance_a == '0)
    else $error("distance reported for a timed-out sensor");

  a_flags_need_done: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.done_res |-> !result.error_a && !result.error_b)
    else $error("error flag outside a done result");
`endif

endmodule
